FILE: hdl/fragment_bond_length_sum_check_unit_defines.svh
// Assertion macros for the fragment bond-length sum check unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef FRAGMENT_BOND_LENGTH_SUM_CHECK_UNIT_DEFINES_SVH
`define FRAGMENT_BOND_LENGTH_SUM_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FBLSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define FBLSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fblsc_pkg.sv
// Package for the fragment bond-length sum check unit: widths, pair tables,
// register codes, sequencer states and the square-root status struct.
package fblsc_pkg;

  localparam int NUM_ATOMS_DEF   = 36;
  localparam int FRAC_BITS       = 12;
  localparam int GROUP_SIZE      = 12;
  localparam int PAIRS_PER_GROUP = 9;
  localparam int PAIR_W          = 4;

  localparam int COORD_W = 24;
  localparam int ENTRY_W = 3 * COORD_W;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RAD_W   = SQ_W + 2;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int ITER_W  = $clog2(ROOT_W);
  localparam int SUM_W   = 30;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 3;

  // Window reset values: 42.75 and 43.75 in Q(FRAC_BITS)
  localparam logic [SUM_W-1:0] WIN_LOW_RST  = SUM_W'((171 << FRAC_BITS) >> 2);
  localparam logic [SUM_W-1:0] WIN_HIGH_RST = SUM_W'((175 << FRAC_BITS) >> 2);

  localparam logic [PAIR_W-1:0] PAIR_A [PAIRS_PER_GROUP] =
    '{4'd0, 4'd0, 4'd0, 4'd3, 4'd7, 4'd7, 4'd9, 4'd6, 4'd6};
  localparam logic [PAIR_W-1:0] PAIR_B [PAIRS_PER_GROUP] =
    '{4'd1, 4'd2, 4'd3, 4'd5, 4'd5, 4'd9, 4'd11, 4'd11, 4'd5};

  typedef enum logic {
    REG_WIN_LOW  = 1'b0,
    REG_WIN_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_A,
    S_RD_B,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

FILE: hdl/fblsc_if.sv
// Valid/ready channel interfaces for the fragment bond-length sum check unit.
// Depends on fblsc_pkg for field widths.
interface fblsc_atom_if import fblsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface fblsc_result_if import fblsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance_sum;
  logic             in_window;

  modport source (output valid, distance_sum, in_window, input ready);
  modport sink   (input valid, distance_sum, in_window, output ready);
endinterface

FILE: hdl/fragment_bond_length_sum_check_unit.sv
// Fragment bond-length sum check unit, top level.
// Depends on fblsc_pkg, fblsc_if (channel interfaces), fblsc_sqrt and the defines header.
//
// Usage: atoms of one fragment arrive one beat per atom on in_if (x, y, z in
// signed Q12), in atom order. Each beat is stored in an on-chip coordinate
// memory; beats other than the last give no result. The last atom's beat
// (atom NUM_ATOMS-1) starts the sequencer, which walks the nine fixed pairs
// of every complete group of 12 atoms. Per pair: two memory reads, three
// squared differences through one shared multiplier, then one shared
// iterative square root (two radicand bits a cycle, 25 steps). That square
// root sets the pace; the result beat appears on out_if once the pairs of
// all groups are summed, and no atoms are taken before that.
// in_if.ready is high only while loading atoms.
// If the receiver stalls, the result waits in the output register; atoms of
// the next fragment are still taken, and its own result waits until the
// previous one is gone. Window registers are written over the APB-style port.
// Reset (rst_n, synchronous) clears the atom count, sequencer and output
// valid and restores the window to 42.75 .. 43.75; memory contents are kept.
`include "fragment_bond_length_sum_check_unit_defines.svh"

module fragment_bond_length_sum_check_unit import fblsc_pkg::*; #(
  parameter int NUM_ATOMS = NUM_ATOMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fblsc_atom_if.sink        in_if,
  fblsc_result_if.source    out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W      = $clog2(NUM_ATOMS);
  localparam int NUM_GROUPS = NUM_ATOMS / GROUP_SIZE;
  localparam logic [CNT_W-1:0]  LAST_ATOM = CNT_W'(NUM_ATOMS - 1);
  localparam logic [CNT_W-1:0]  LAST_BASE = CNT_W'((NUM_GROUPS - 1) * GROUP_SIZE);
  localparam logic [CNT_W-1:0]  BASE_STEP = CNT_W'(GROUP_SIZE);
  localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS_PER_GROUP - 1);

  // ---------------------------------------------------------------- config
  logic [SUM_W-1:0] win_low_r, win_high_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WIN_LOW_RST;
      win_high_r <= WIN_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[2]))
        REG_WIN_LOW:  win_low_r  <= pwdata[SUM_W-1:0];
        REG_WIN_HIGH: win_high_r <= pwdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_WIN_LOW:  prdata = CFG_DW'(win_low_r);
      REG_WIN_HIGH: prdata = CFG_DW'(win_high_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;      // next atom to store
  logic [CNT_W-1:0]   base_r, base_nxt;    // first atom of current group
  logic [PAIR_W-1:0]  pair_r, pair_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [ENTRY_W-1:0] mem [NUM_ATOMS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] atom_a_r;
  logic [SQ_W-1:0]    sq_r;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_win_r;

  // control from the sequencer
  logic               in_accept;
  logic               rd_en;
  logic [CNT_W-1:0]   rd_addr;
  logic               atom_a_ld;
  logic               sq_ld;
  logic               rad_ld;
  logic               rad_clr;
  logic               sum_clr;
  logic               sum_ld;
  logic               out_ld;
  logic               sq_start;

  // shared arithmetic
  logic signed [COORD_W-1:0] coord_a, coord_b;
  logic signed [COORD_W:0]   diff;
  logic [MAG_W-1:0]          mag;
  logic [SUM_W:0]            sum_add;
  logic                      win_hit;
  sqrt_stat_t                sq_stat;
  logic [ROOT_W-1:0]         sq_root;

  function automatic logic signed [COORD_W-1:0] pick_axis(
    input logic [ENTRY_W-1:0] entry,
    input logic [1:0]         axis
  );
    logic signed [COORD_W-1:0] val;
    case (axis)
      2'd0:    val = entry[COORD_W-1:0];
      2'd1:    val = entry[2*COORD_W-1:COORD_W];
      default: val = entry[3*COORD_W-1:2*COORD_W];
    endcase
    return val;
  endfunction

  assign in_if.ready = (state_r == S_LOAD);
  assign in_accept   = in_if.valid & in_if.ready;

  assign coord_a = pick_axis(atom_a_r, axis_r);
  assign coord_b = pick_axis(rd_data_r, axis_r);
  assign diff    = {coord_a[COORD_W-1], coord_a} - {coord_b[COORD_W-1], coord_b};
  // |diff| < 2^24, fits in MAG_W
  assign mag     = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);

  assign rad_nxt = rad_r + RAD_W'(sq_r);
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(sq_root);
  assign sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];   // saturate
  assign win_hit = (sum_r >= win_low_r) && (sum_r <= win_high_r);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    pair_nxt      = pair_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = base_r + CNT_W'(PAIR_A[pair_r]);
    atom_a_ld     = 1'b0;
    sq_ld         = 1'b0;
    rad_ld        = 1'b0;
    rad_clr       = 1'b0;
    sum_clr       = 1'b0;
    sum_ld        = 1'b0;
    out_ld        = 1'b0;
    sq_start      = 1'b0;

    if (out_if.valid && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          if (cnt_r == LAST_ATOM) begin
            cnt_nxt   = '0;
            base_nxt  = '0;
            pair_nxt  = '0;
            sum_clr   = 1'b1;
            state_nxt = S_RD_A;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_RD_A: begin
        rd_en     = 1'b1;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        rd_en     = 1'b1;
        rd_addr   = base_r + CNT_W'(PAIR_B[pair_r]);
        atom_a_ld = 1'b1;
        axis_nxt  = '0;
        rad_clr   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        sq_ld     = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rad_ld = 1'b1;
        if (axis_r == 2'd2) begin
          sq_start  = 1'b1;
          state_nxt = S_SQRT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_SQRT: begin
        if (sq_stat.done) begin
          sum_ld = 1'b1;
          if (pair_r == LAST_PAIR) begin
            pair_nxt = '0;
            if (base_r == LAST_BASE) begin
              state_nxt = S_DONE;
            end else begin
              base_nxt  = base_r + BASE_STEP;
              state_nxt = S_RD_A;
            end
          end else begin
            pair_nxt  = pair_r + 1'b1;
            state_nxt = S_RD_A;
          end
        end
      end
      S_DONE: begin
        // wait until the previous result beat has left
        if (!out_valid_r || out_if.ready) begin
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      base_r      <= '0;
      pair_r      <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      pair_r      <= pair_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------- coordinate memory
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[cnt_r] <= {in_if.coord_z, in_if.coord_y, in_if.coord_x};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (atom_a_ld) atom_a_r <= rd_data_r;
    if (sq_ld)     sq_r     <= mag * mag;
    if (rad_clr)   rad_r    <= '0;
    else if (rad_ld) rad_r  <= rad_nxt;
    if (sum_clr)   sum_r    <= '0;
    else if (sum_ld) sum_r  <= sum_nxt;
    if (out_ld) begin
      out_sum_r <= sum_r;
      out_win_r <= win_hit;
    end
  end

  fblsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rad_nxt),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.distance_sum = out_sum_r;
  assign out_if.in_window    = out_win_r;

  // ---------------------------------------------------------------- checks
  `FBLSC_ASSERT_IMP(a_sqrt_no_restart, sq_start, !sq_stat.busy, "sqrt restarted while busy")
  `FBLSC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= LAST_ATOM, "atom count out of range")
  `FBLSC_ASSERT_NXT(a_last_atom_starts, in_accept && (cnt_r == LAST_ATOM),
                    (state_r == S_RD_A) && (cnt_r == '0), "last atom did not start pairs")
  `FBLSC_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r == S_DONE),
                    "result beat raised outside done step")

endmodule

FILE: hdl/fblsc_sqrt.sv
// Iterative integer square root, two radicand bits per cycle (floor result).
// Depends on fblsc_pkg for widths and the status struct.
module fblsc_sqrt import fblsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output sqrt_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              take;

  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign take    = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ITER_W'(ROOT_W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath: one root bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (take) begin
        rem_r  <= rem_sub[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule
